### hw/rtl/bam_pkg.sv
package bam_pkg;

	localparam int unsigned WORD_W  = 16;
	localparam int unsigned SHIFT_W = 4;
	localparam int unsigned CFG_IDX_W = 3;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CONTROL_ZERO = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROL_ONE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_MASK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_MASK    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRELOAD_A    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRELOAD_B    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PRELOAD_C    = 3'd6;

	// control_zero bit positions
	localparam int unsigned CZ_USE_A = 11;
	localparam int unsigned CZ_USE_B = 10;
	localparam int unsigned CZ_USE_C = 9;
	localparam int unsigned CZ_USE_D = 8;

	// control_one bit positions
	localparam int unsigned C1_DESC = 1;
	localparam int unsigned C1_LINE = 0;

	// settings the shift and logic unit needs
	typedef struct packed {
		logic [SHIFT_W-1:0] a_shift;
		logic [SHIFT_W-1:0] b_shift;
		logic               desc;
		logic [7:0]         minterm;
	} bam_shift_cfg_t;

endpackage

### hw/rtl/bam_datapath.sv
module bam_datapath
	import bam_pkg::*;
(
	input  bam_shift_cfg_t      cfg,
	input  logic [WORD_W-1:0]   word_am,
	input  logic [WORD_W-1:0]   word_b,
	input  logic [WORD_W-1:0]   word_c,
	input  logic [WORD_W-1:0]   prev_a,
	input  logic [WORD_W-1:0]   prev_b,
	output logic [WORD_W-1:0]   word_d
);

	// funnel shift of the current word against the previous one
	function automatic logic [WORD_W-1:0] shift_pair(
		input logic [WORD_W-1:0]  cur,
		input logic [WORD_W-1:0]  prev,
		input logic [SHIFT_W-1:0] sh,
		input logic               desc
	);
		logic [2*WORD_W-1:0] joined;
		logic [SHIFT_W:0]    amt;
		begin
			if (!desc) begin
				joined = {prev, cur};
				amt    = {1'b0, sh};
			end else begin
				joined = {cur, prev};
				amt    = (SHIFT_W+1)'(WORD_W) - {1'b0, sh};
			end
			shift_pair = joined[WORD_W-1:0];
			joined     = joined >> amt;
			shift_pair = joined[WORD_W-1:0];
		end
	endfunction

	logic [WORD_W-1:0] a_sh;
	logic [WORD_W-1:0] b_sh;

	assign a_sh = shift_pair(word_am, prev_a, cfg.a_shift, cfg.desc);
	assign b_sh = shift_pair(word_b, prev_b, cfg.b_shift, cfg.desc);

	// each bit picks its minterm entry by the {a,b,c} bit triple
	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			word_d[j] = cfg.minterm[{a_sh[j], b_sh[j], word_c[j]}];
		end
	end

endmodule

### hw/rtl/blitter_area_minterm_datapath.sv
// Area-mode blitter datapath. Each input transaction is one word position of a
// blit (source words A, B, C and the row/blit boundary flags) and yields exactly
// one output transaction: the destination word D, its write enable, a nonzero
// flag and a done pulse on the last word of the blit. Disabled source channels
// take their preload register, A is masked on the first and last word of a row,
// A and B are funnel-shifted against the previous A and B words (right when
// ascending, left when descending) and the 8-bit minterm combines the three
// words bit by bit. In line mode D is still produced but write_d and done_irq
// stay low. Throughput is one transaction per cycle while out_stall is low. An
// accepted transaction sits in the input register and moves on to the result
// register, which drives the outputs, once that register is free or being
// taken. The carried previous-A/previous-B words are updated as each word
// leaves the input register, so back-to-back words chain correctly. A full
// output register backs stall up to the input. Configuration is written through
// cfg_we, cfg_index and cfg_data and must only change while no transaction is
// in flight.
module blitter_area_minterm_datapath
	import bam_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0]     cfg_data,

	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [WORD_W-1:0]     word_a,
	input  logic [WORD_W-1:0]     word_b,
	input  logic [WORD_W-1:0]     word_c,
	input  logic                  row_first,
	input  logic                  row_last,
	input  logic                  blit_first,
	input  logic                  blit_last,

	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [WORD_W-1:0]     word_d,
	output logic                  write_d,
	output logic                  nonzero,
	output logic                  done_irq
);

	// configuration registers
	logic [WORD_W-1:0] control_zero_q;
	logic [WORD_W-1:0] control_one_q;
	logic [WORD_W-1:0] first_mask_q;
	logic [WORD_W-1:0] last_mask_q;
	logic [WORD_W-1:0] preload_a_q;
	logic [WORD_W-1:0] preload_b_q;
	logic [WORD_W-1:0] preload_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_zero_q <= '0;
			control_one_q  <= '0;
			first_mask_q   <= '1;
			last_mask_q    <= '1;
			preload_a_q    <= '0;
			preload_b_q    <= '0;
			preload_c_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CONTROL_ZERO: control_zero_q <= cfg_data;
				REG_CONTROL_ONE:  control_one_q  <= cfg_data;
				REG_FIRST_MASK:   first_mask_q   <= cfg_data;
				REG_LAST_MASK:    last_mask_q    <= cfg_data;
				REG_PRELOAD_A:    preload_a_q    <= cfg_data;
				REG_PRELOAD_B:    preload_b_q    <= cfg_data;
				REG_PRELOAD_C:    preload_c_q    <= cfg_data;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// decoded control fields
	logic use_a, use_b, use_c, use_d, line_mode;
	bam_shift_cfg_t shift_cfg;

	assign use_a     = control_zero_q[CZ_USE_A];
	assign use_b     = control_zero_q[CZ_USE_B];
	assign use_c     = control_zero_q[CZ_USE_C];
	assign use_d     = control_zero_q[CZ_USE_D];
	assign line_mode = control_one_q[C1_LINE];

	assign shift_cfg.a_shift = control_zero_q[WORD_W-1 -: SHIFT_W];
	assign shift_cfg.b_shift = control_one_q[WORD_W-1 -: SHIFT_W];
	assign shift_cfg.desc    = control_one_q[C1_DESC];
	assign shift_cfg.minterm = control_zero_q[7:0];

	// handshake: stage 1 moves on when the result register is free or draining
	logic s1_valid_q;
	logic s2_valid_q;
	logic in_take;
	logic s1_move;

	assign s1_move   = s1_valid_q && (!s2_valid_q || !out_stall);
	assign in_stall  = s1_valid_q && !s1_move;
	assign in_take   = in_valid && !in_stall;
	assign out_valid = s2_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				s2_valid_q <= 1'b1;
			end else if (!out_stall) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	// input register, payload only
	logic [WORD_W-1:0] word_a_s1, word_b_s1, word_c_s1;
	logic              row_first_s1, row_last_s1, blit_first_s1, blit_last_s1;

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_a_s1     <= word_a;
			word_b_s1     <= word_b;
			word_c_s1     <= word_c;
			row_first_s1  <= row_first;
			row_last_s1   <= row_last;
			blit_first_s1 <= blit_first;
			blit_last_s1  <= blit_last;
		end
	end

	// source select, masking and carried words
	logic [WORD_W-1:0] a_src, b_src, c_src, a_masked;
	logic [WORD_W-1:0] prev_a_q, prev_b_q, prev_a_use, prev_b_use;
	logic [WORD_W-1:0] d_comb;

	assign a_src = use_a ? word_a_s1 : preload_a_q;
	assign b_src = use_b ? word_b_s1 : preload_b_q;
	assign c_src = use_c ? word_c_s1 : preload_c_q;

	// a one-word row gets both masks
	assign a_masked = a_src & (row_first_s1 ? first_mask_q : '1)
	                        & (row_last_s1  ? last_mask_q  : '1);

	// start of blit sees zero history
	assign prev_a_use = blit_first_s1 ? '0 : prev_a_q;
	assign prev_b_use = blit_first_s1 ? '0 : prev_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= '0;
			prev_b_q <= '0;
		end else if (s1_move) begin
			prev_a_q <= a_masked;
			prev_b_q <= b_src;
		end
	end

	bam_datapath u_datapath (
		.cfg     (shift_cfg),
		.word_am (a_masked),
		.word_b  (b_src),
		.word_c  (c_src),
		.prev_a  (prev_a_use),
		.prev_b  (prev_b_use),
		.word_d  (d_comb)
	);

	// result register
	logic [WORD_W-1:0] word_d_s2;
	logic              write_d_s2, nonzero_s2, done_irq_s2;

	always_ff @(posedge clk) begin
		if (s1_move) begin
			word_d_s2   <= d_comb;
			write_d_s2  <= use_d && !line_mode;
			nonzero_s2  <= |d_comb;
			done_irq_s2 <= blit_last_s1 && !line_mode;
		end
	end

	assign word_d   = word_d_s2;
	assign write_d  = write_d_s2;
	assign nonzero  = nonzero_s2;
	assign done_irq = done_irq_s2;

`ifndef SYNTHESIS
	// input side only backs up when an item is waiting in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && s2_valid_q && out_stall))
		else $error("input stalled without a full pipeline");

	// an item leaving stage 1 always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> s2_valid_q)
		else $error("result register lost a transaction");

	// nonzero flag tracks the delivered word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (nonzero == (word_d != '0)))
		else $error("nonzero flag does not match word_d");

	// line mode suppresses both write and done
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (write_d || done_irq)) |-> !line_mode)
		else $error("write or done given in line mode");

	// carried words only change when an item advances
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(s1_move) |-> ($stable(prev_a_q) && $stable(prev_b_q)))
		else $error("carried words changed without an item");
`endif

endmodule

### tb/sv/tb_blitter_area_minterm_datapath.sv
module tb_blitter_area_minterm_datapath;
	import bam_pkg::*;

	// generous cycle budget: about 2000 transactions with random gaps
	// and stalls, plus the long hold-off
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SHOWN_ERRORS = 10;
	localparam int unsigned IDLE_PCT = 13;
	localparam int unsigned RANDOM_PHASES = 12;
	localparam int unsigned PHASE_WORDS = 150;
	// index with no register behind it, writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// one word position of a blit
	typedef struct packed {
		logic [WORD_W-1:0] word_a;
		logic [WORD_W-1:0] word_b;
		logic [WORD_W-1:0] word_c;
		logic              row_first;
		logic              row_last;
		logic              blit_first;
		logic              blit_last;
	} src_word_t;

	// one destination transaction
	typedef struct packed {
		logic [WORD_W-1:0] word_d;
		logic              write_d;
		logic              nonzero;
		logic              done_irq;
	} dest_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;

	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [WORD_W-1:0] word_a = '0;
	logic [WORD_W-1:0] word_b = '0;
	logic [WORD_W-1:0] word_c = '0;
	logic              row_first = 1'b0;
	logic              row_last = 1'b0;
	logic              blit_first = 1'b0;
	logic              blit_last = 1'b0;

	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [WORD_W-1:0] word_d;
	logic              write_d;
	logic              nonzero;
	logic              done_irq;

	// mirror of the configuration registers, reset values
	logic [WORD_W-1:0] ctl_zero = '0;
	logic [WORD_W-1:0] ctl_one = '0;
	logic [WORD_W-1:0] first_mask = '1;
	logic [WORD_W-1:0] last_mask = '1;
	logic [WORD_W-1:0] fill_a = '0;
	logic [WORD_W-1:0] fill_b = '0;
	logic [WORD_W-1:0] fill_c = '0;
	// words carried from the previous position into the funnel shifters
	logic [WORD_W-1:0] carry_a = '0;
	logic [WORD_W-1:0] carry_b = '0;

	// destination words still owed by the block, oldest first
	dest_word_t pending_dest[$];
	dest_word_t got_d;
	dest_word_t want_d;

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned words_sent = 0;
	int unsigned dests_seen = 0;
	int unsigned settings_used = 0;
	bit          no_idle = 1'b0;
	int unsigned hold_len = 0;
	int unsigned hold_ctr = 0;

	blitter_area_minterm_datapath uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.word_a     (word_a),
		.word_b     (word_b),
		.word_c     (word_c),
		.row_first  (row_first),
		.row_last   (row_last),
		.blit_first (blit_first),
		.blit_last  (blit_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.word_d     (word_d),
		.write_d    (write_d),
		.nonzero    (nonzero),
		.done_irq   (done_irq)
	);

	always #10 clk = ~clk;

	// funnel shift of the current word against the previous one
	// ascending shifts right, descending shifts left, zero shift passes cur
	function automatic logic [WORD_W-1:0] funnel(input logic [WORD_W-1:0] cur,
			input logic [WORD_W-1:0] prev, input logic [SHIFT_W-1:0] sh,
			input logic desc);
		logic [2*WORD_W-1:0] joined;
		if (!desc) begin
			joined = {prev, cur};
			return WORD_W'(joined >> sh);
		end
		joined = {cur, prev};
		return WORD_W'(joined >> (WORD_W - sh));
	endfunction

	// bitwise minterm: bit i of the minterm selects the product term
	// where a, b, c take the values of bits 2, 1, 0 of i
	function automatic logic [WORD_W-1:0] minterm_mix(input logic [7:0] mt,
			input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
			input logic [WORD_W-1:0] c);
		logic [WORD_W-1:0] d;
		logic [WORD_W-1:0] term;
		d = '0;
		for (int i = 0; i < 8; i++) begin
			if (mt[i]) begin
				term = i[2] ? a : ~a;
				term &= i[1] ? b : ~b;
				term &= i[0] ? c : ~c;
				d |= term;
			end
		end
		return d;
	endfunction

	// expected destination for one accepted word, advances the carried words
	function automatic dest_word_t predict_dest(input src_word_t w);
		dest_word_t r;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] a_sh;
		logic [WORD_W-1:0] b_sh;
		logic desc;
		logic line;
		a = ctl_zero[CZ_USE_A] ? w.word_a : fill_a;
		b = ctl_zero[CZ_USE_B] ? w.word_b : fill_b;
		c = ctl_zero[CZ_USE_C] ? w.word_c : fill_c;
		desc = ctl_one[C1_DESC];
		line = ctl_one[C1_LINE];
		// blit start clears the carried words before they are used
		if (w.blit_first) begin
			carry_a = '0;
			carry_b = '0;
		end
		// both masks apply on a one-word row
		if (w.row_first)
			a &= first_mask;
		if (w.row_last)
			a &= last_mask;
		a_sh = funnel(a, carry_a, ctl_zero[WORD_W-1 -: SHIFT_W], desc);
		b_sh = funnel(b, carry_b, ctl_one[WORD_W-1 -: SHIFT_W], desc);
		carry_a = a;
		carry_b = b;
		r.word_d = minterm_mix(ctl_zero[7:0], a_sh, b_sh, c);
		// line mode still computes d but never writes or signals done
		r.write_d = ctl_zero[CZ_USE_D] && !line;
		r.nonzero = r.word_d != '0;
		r.done_irq = w.blit_last && !line;
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return WORD_W'($urandom);
		endcase
	endfunction

	function automatic src_word_t mk_word(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c,
			input logic rf, input logic rl, input logic bf, input logic bl);
		return '{a, b, c, rf, rl, bf, bl};
	endfunction

	task automatic flag_failure(input string msg);
		error_count++;
		if (error_count <= SHOWN_ERRORS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// one register write, only ever issued while the block is idle
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CONTROL_ZERO: ctl_zero = val;
			REG_CONTROL_ONE:  ctl_one = val;
			REG_FIRST_MASK:   first_mask = val;
			REG_LAST_MASK:    last_mask = val;
			REG_PRELOAD_A:    fill_a = val;
			REG_PRELOAD_B:    fill_b = val;
			REG_PRELOAD_C:    fill_c = val;
			default: ;
		endcase
	endtask

	task automatic load_setting(input logic [WORD_W-1:0] cz, input logic [WORD_W-1:0] c1,
			input logic [WORD_W-1:0] fm, input logic [WORD_W-1:0] lm,
			input logic [WORD_W-1:0] pa, input logic [WORD_W-1:0] pb,
			input logic [WORD_W-1:0] pc);
		cfg_write(REG_CONTROL_ZERO, cz);
		cfg_write(REG_CONTROL_ONE, c1);
		cfg_write(REG_FIRST_MASK, fm);
		cfg_write(REG_LAST_MASK, lm);
		cfg_write(REG_PRELOAD_A, pa);
		cfg_write(REG_PRELOAD_B, pb);
		cfg_write(REG_PRELOAD_C, pc);
		settings_used++;
	endtask

	// offer one input transaction, holding it until the block takes it
	task automatic send_word(input src_word_t w);
		dest_word_t owed;
		@(negedge clk);
		if (!no_idle) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		word_a <= w.word_a;
		word_b <= w.word_b;
		word_c <= w.word_c;
		row_first <= w.row_first;
		row_last <= w.row_last;
		blit_first <= w.blit_first;
		blit_last <= w.blit_last;
		do
			@(posedge clk);
		while (in_stall);
		owed = predict_dest(w);
		pending_dest = {pending_dest, owed};
		words_sent++;
	endtask

	// stop offering, wait for every owed result, then cover the pipeline depth
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_dest.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one blit of rows x width word positions with proper boundary flags;
	// cut below the full size leaves a broken blit with no last word
	task automatic send_blit(input int unsigned rows, input int unsigned width,
			input int unsigned cut);
		int unsigned total;
		int unsigned col;
		total = rows * width;
		for (int unsigned k = 0; k < total && k < cut; k++) begin
			col = k % width;
			send_word(mk_word(rand_word(), rand_word(), rand_word(),
				col == 0, col == width - 1, k == 0, k == total - 1));
		end
	endtask

	// receiver side: random stalls, quiet stretches and the long hold-off
	always @(negedge clk) begin
		if (hold_len != 0) begin
			hold_ctr = hold_len;
			hold_len = 0;
		end
		if (hold_ctr > 0) begin
			out_stall <= 1'b1;
			hold_ctr--;
		end else if (no_idle) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	// compare every output transaction with the oldest owed destination word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_d = '{word_d, write_d, nonzero, done_irq};
			dests_seen++;
			if (pending_dest.size() == 0) begin
				flag_failure($sformatf("unexpected result d=%h we=%b nz=%b done=%b",
					got_d.word_d, got_d.write_d, got_d.nonzero, got_d.done_irq));
			end else begin
				want_d = pending_dest.pop_front();
				if (got_d !== want_d)
					flag_failure($sformatf(
						"exp d=%h we=%b nz=%b done=%b got d=%h we=%b nz=%b done=%b",
						want_d.word_d, want_d.write_d, want_d.nonzero, want_d.done_irq,
						got_d.word_d, got_d.write_d, got_d.nonzero, got_d.done_irq));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
				cycle_count, pending_dest.size());
			$display("** blitter_area_minterm_datapath: FAILED **");
			$finish;
		end
	end

	// reset values: minterm zero gives d zero, masks all ones
	task automatic test_reset_state();
		send_word(mk_word('1, '1, '1, 1'b1, 1'b1, 1'b1, 1'b1));
		send_word(mk_word(16'h5a5a, 16'ha5a5, 16'h0f0f, 1'b0, 1'b0, 1'b0, 1'b0));
		drain();
	endtask

	// hand-picked words: field extremes, masks, shifts, modes, minterms
	task automatic test_directed();
		// max shifts ascending, masks on row edges, mux minterm
		load_setting(16'hffca, 16'hf000, 16'h00ff, 16'hff00, 16'h1234, 16'h5678, 16'h9abc);
		cfg_write(REG_UNUSED, 16'hffff);
		send_word(mk_word(16'hffff, 16'h0000, 16'haaaa, 1'b1, 1'b0, 1'b1, 1'b0));
		send_word(mk_word(16'h0000, 16'hffff, 16'h5555, 1'b0, 1'b0, 1'b0, 1'b0));
		send_word(mk_word(16'h8001, 16'h7ffe, 16'hffff, 1'b0, 1'b1, 1'b0, 1'b0));
		// one-word row gets both masks
		send_word(mk_word(16'hffff, 16'hffff, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0));
		send_word(mk_word(16'h1234, 16'h5678, 16'h9abc, 1'b0, 1'b0, 1'b0, 1'b0));
		send_word(mk_word(16'hffff, 16'h0001, 16'h8000, 1'b1, 1'b1, 1'b0, 1'b1));
		drain();
		// descending with zero shift passes a straight through
		load_setting(16'h0ff0, 16'h0002, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000);
		send_word(mk_word(16'hc3a5, 16'h1111, 16'h2222, 1'b1, 1'b0, 1'b1, 1'b0));
		send_word(mk_word(16'hffff, 16'h3333, 16'h4444, 1'b0, 1'b1, 1'b0, 1'b0));
		send_word(mk_word(16'h0001, 16'h5555, 16'h6666, 1'b1, 1'b1, 1'b0, 1'b1));
		drain();
		// descending with real shifts, d follows shifted b
		load_setting(16'h8fcc, 16'h4002, 16'hf0f0, 16'h0f0f, 16'h0000, 16'h0000, 16'h0000);
		send_word(mk_word(16'habcd, 16'h8421, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0));
		send_word(mk_word(16'h1357, 16'h1248, 16'hffff, 1'b0, 1'b1, 1'b0, 1'b1));
		drain();
		// line mode: d still produced, no write and no done
		load_setting(16'h0ffe, 16'h0001, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000);
		send_word(mk_word(16'h0000, 16'h0000, 16'h0001, 1'b1, 1'b0, 1'b1, 1'b0));
		send_word(mk_word(16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b1));
		drain();
		// every channel off, preloads feed the minterm, masks clear a on the row-first word
		load_setting(16'h00ff, 16'h8002, 16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'hffff);
		send_word(mk_word(16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b0, 1'b1, 1'b0));
		send_word(mk_word(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1));
		drain();
		// minterm zero: d zero, nonzero low, write still enabled
		load_setting(16'hf100, 16'h0000, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000);
		send_word(mk_word(16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b1, 1'b1, 1'b1));
		send_word(mk_word(16'h7777, 16'h8888, 16'h9999, 1'b0, 1'b0, 1'b0, 1'b0));
		drain();
	endtask

	// random settings, mostly well-formed blits with random content
	task automatic test_random_blits();
		int unsigned start;
		int unsigned pick;
		logic [WORD_W-1:0] c1;
		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				load_setting('0, '0, '0, '0, '0, '0, '0);
			end else if (p == 1) begin
				load_setting('1, '1, '1, '1, '1, '1, '1);
			end else begin
				// line mode in about a quarter of the settings
				c1 = WORD_W'($urandom);
				c1[C1_LINE] = ($urandom_range(3) == 0);
				load_setting(rand_word(), c1, rand_word(), rand_word(), rand_word(),
					rand_word(), rand_word());
				if ($urandom_range(2) == 0)
					cfg_write(REG_UNUSED, rand_word());
			end
			// one phase with no idling on either side
			no_idle = (p == 5);
			start = words_sent;
			while (words_sent - start < PHASE_WORDS) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					send_blit($urandom_range(1, 4), $urandom_range(1, 6), '1);
				end else if (pick < 90) begin
					send_blit($urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 8));
				end else begin
					repeat ($urandom_range(1, 3))
						send_word(mk_word(rand_word(), rand_word(), rand_word(),
							1'($urandom_range(1)), 1'($urandom_range(1)),
							1'($urandom_range(1)), 1'($urandom_range(1))));
				end
			end
			drain();
			no_idle = 1'b0;
		end
	endtask

	// receiver holds off while the sender keeps offering, block must back up
	task automatic test_backpressure();
		load_setting(16'h4fe8, 16'h9000, 16'h7fff, 16'hfffe, 16'h0000, 16'h0000, 16'h0000);
		no_idle = 1'b1;
		hold_len = 60;
		send_blit(4, 6, '1);
		send_blit(2, 5, '1);
		drain();
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_directed();
		test_random_blits();
		test_backpressure();
		drain();
		$display("%0d word transactions over %0d register settings, %0d results checked",
			words_sent, settings_used, dests_seen);
		$display("covered masks, both shift directions, line mode, preloads and a long stall");
		if (error_count == 0 && pending_dest.size() == 0) begin
			$display("** blitter_area_minterm_datapath: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results missing", error_count, pending_dest.size());
			$display("** blitter_area_minterm_datapath: FAILED **");
		end
		$finish;
	end

endmodule
